[rtl/core/sfla_pkg.sv]
// ----------------------------------------------------------------------------
// sfla_pkg
// Types and constants shared by the slab free list allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfla_pkg;

   localparam int ADDR_W = 32;
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_SIZE = 8'd2;

   localparam logic [ADDR_W-1:0] OBJECT_SIZE_RESET = 32'd8;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_REUSED  = 3'd0,
      ST_FRESH   = 3'd1,
      ST_NOSPACE = 3'd2,
      ST_FREED   = 3'd3,
      ST_DROPPED = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/sfla_fifo.sv]
// ----------------------------------------------------------------------------
// sfla_fifo
// Two-entry queue that decouples the request side, the execution unit and
// the response side from each other.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_fifo #(
   parameter int WIDTH = 33
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   logic [WIDTH-1:0] entries_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/sfla_back.sv]
// ----------------------------------------------------------------------------
// sfla_back
// Execution unit: keeps the bump offset and the LIFO store of freed
// addresses, and turns each queued command into one response word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_back #(
   parameter int FREE_DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sfla_pkg::ADDR_W-1:0]   region_base,
   input  wire logic [sfla_pkg::ADDR_W-1:0]   region_size,
   input  wire logic [sfla_pkg::ADDR_W-1:0]   object_size,
   input  wire logic                          cmd_valid,
   input  wire sfla_pkg::cmd_type             cmd,
   output logic                               cmd_pop,
   input  wire logic                          rsp_full,
   output logic                               rsp_push,
   output sfla_pkg::rsp_type                  rsp
);

   localparam int CNT_W = $clog2(FREE_DEPTH + 1);
   localparam int IDX_W = $clog2(FREE_DEPTH);

   sfla_pkg::back_state_type      state_ff;
   sfla_pkg::back_state_type      state_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [sfla_pkg::ADDR_W-1:0]   bump_ff;
   logic [sfla_pkg::ADDR_W-1:0]   bump_in;
   logic [sfla_pkg::ADDR_W-1:0]   store_mem [FREE_DEPTH];
   logic [sfla_pkg::ADDR_W-1:0]   rd_data_ff;
   logic                          rd_en;
   logic                          wr_en;
   logic [IDX_W-1:0]              rd_idx;
   logic [IDX_W-1:0]              wr_idx;
   logic [sfla_pkg::ADDR_W-1:0]   end_sum;

   assign end_sum = bump_ff + object_size;
   assign rd_idx  = count_in[IDX_W-1:0];
   assign wr_idx  = count_ff[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      bump_in     = bump_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      rsp.addr    = '0;
      rsp.status  = sfla_pkg::ST_FREED;
      case (state_ff)
         sfla_pkg::BK_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               if (cmd.op == sfla_pkg::OP_ALLOC) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                     rd_en    = 1'b1;
                     state_in = sfla_pkg::BK_READ;
                  end else begin
                     rsp_push = 1'b1;
                     if (end_sum >= region_size) begin
                        rsp.status = sfla_pkg::ST_NOSPACE;
                     end else begin
                        rsp.addr   = region_base + bump_ff;
                        rsp.status = sfla_pkg::ST_FRESH;
                        bump_in    = end_sum;
                     end
                  end
               end else begin
                  rsp_push = 1'b1;
                  if (count_ff != CNT_W'(FREE_DEPTH)) begin
                     wr_en      = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                     rsp.status = sfla_pkg::ST_FREED;
                  end else begin
                     rsp.status = sfla_pkg::ST_DROPPED;
                  end
               end
            end
         end
         sfla_pkg::BK_READ: begin
            rsp_push   = 1'b1;
            rsp.addr   = rd_data_ff;
            rsp.status = sfla_pkg::ST_REUSED;
            state_in   = sfla_pkg::BK_IDLE;
         end
         default: begin
            state_in = sfla_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfla_pkg::BK_IDLE;
         count_ff <= '0;
         bump_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bump_ff  <= bump_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_idx] <= cmd.addr;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

[rtl/core/slab_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// Fixed-size object allocator with a LIFO store of freed addresses.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and responses leave through another, so
// both sides may stall independently. A free, a fresh allocation or a failed
// allocation is answered from the idle state; reusing a freed address also
// passes the read state, as the free store is a memory with a registered
// read port. The free store needs no clearing after reset, so requests are
// taken from the first cycle after reset. Configuration writes are always
// ready and must only be issued while no request is in flight.
`default_nettype none

module slab_free_list_allocator #(
   parameter int FREE_DEPTH = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic                              req_kind,
   input  wire logic [sfla_pkg::ADDR_W-1:0]       req_free_address,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [sfla_pkg::ADDR_W-1:0]            rsp_block_address,
   output logic [2:0]                             rsp_status,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sfla_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sfla_pkg::ADDR_W-1:0]       csr_data
);

   logic [sfla_pkg::ADDR_W-1:0] region_base_ff;
   logic [sfla_pkg::ADDR_W-1:0] region_size_ff;
   logic [sfla_pkg::ADDR_W-1:0] object_size_ff;
   logic                        csr_write;

   sfla_pkg::cmd_type           req_cmd;
   sfla_pkg::cmd_type           cmd;
   logic                        cmd_empty;
   logic                        cmd_pop;
   sfla_pkg::rsp_type           back_rsp;
   sfla_pkg::rsp_type           out_rsp;
   logic                        back_rsp_push;
   logic                        rsp_full;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= '0;
         object_size_ff <= sfla_pkg::OBJECT_SIZE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sfla_pkg::CSR_REGION_BASE: region_base_ff <= csr_data;
            sfla_pkg::CSR_REGION_SIZE: region_size_ff <= csr_data;
            sfla_pkg::CSR_OBJECT_SIZE: object_size_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_cmd.op   = req_kind ? sfla_pkg::OP_FREE : sfla_pkg::OP_ALLOC;
      req_cmd.addr = req_free_address;
   end

   sfla_fifo #(
      .WIDTH ($bits(sfla_pkg::cmd_type))
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_cmd),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   sfla_back #(
      .FREE_DEPTH (FREE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .region_base (region_base_ff),
      .region_size (region_size_ff),
      .object_size (object_size_ff),
      .cmd_valid   (!cmd_empty),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (back_rsp_push),
      .rsp         (back_rsp)
   );

   sfla_fifo #(
      .WIDTH ($bits(sfla_pkg::rsp_type))
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (back_rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (out_rsp),
      .empty   (rsp_empty)
   );

   assign rsp_block_address = out_rsp.addr;
   assign rsp_status        = out_rsp.status;

endmodule

`default_nettype wire

[rtl/core/sfla_checker.sv]
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks on the allocator's queues and response side, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [31:0] rsp_block_address,
   input wire logic [2:0]  rsp_status
);

   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_status_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == sfla_pkg::ST_REUSED || rsp_status == sfla_pkg::ST_FRESH ||
                      rsp_status == sfla_pkg::ST_NOSPACE || rsp_status == sfla_pkg::ST_FREED ||
                      rsp_status == sfla_pkg::ST_DROPPED))
      else $error("response status out of range");

   a_zero_address : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == sfla_pkg::ST_NOSPACE ||
                      rsp_status == sfla_pkg::ST_FREED ||
                      rsp_status == sfla_pkg::ST_DROPPED)) |-> rsp_block_address == 32'd0)
      else $error("nonzero address on a response that carries none");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_block_address) &&
                                   $stable(rsp_status))
      else $error("stalled response word changed");

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_block_address (rsp_block_address),
   .rsp_status        (rsp_status)
);

`default_nettype wire
